[rtl/asbb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asbb_pkg: shared types and constants
// Widths, limits and the command/status structs of the row box blur.
// ----------------------------------------------------------------------------
package asbb_pkg;

  localparam int MAX_RADIUS = 32;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;

  localparam int PIX_W      = 32;
  localparam int COL_W      = 12;
  localparam int PTR_W      = 7;
  localparam int SUM_W      = 15;
  localparam int DIV_W      = 7;
  localparam int RAD_W      = 6;
  localparam int DIM_W      = 13;
  localparam int JW         = 14;
  localparam int DCNT_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_RADIUS   = 2'd0,
    REG_LINE_WIDTH   = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic accept;
    logic sum_start;
    logic div_start;
    logic load;
    logic finish;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic end_row;
    logic emit_one;
    logic last_x;
    logic sum_done;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

[rtl/asbb_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asbb channel interfaces
// Pixel input, blurred result and configuration write channels.
// ----------------------------------------------------------------------------
interface asbb_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface asbb_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic [11:0] out_column;
  logic [11:0] out_row;
  logic        row_done;
  logic        image_done;
  modport source (output valid, output pixel_out, output out_column, output out_row,
                  output row_done, output image_done, input ready);
  modport sink   (input valid, input pixel_out, input out_column, input out_row,
                  input row_done, input image_done, output ready);
endinterface

interface asbb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/asbb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asbb_ctrl: sequencer
// Steps each request that yields results through window sum, division and result load.
// ----------------------------------------------------------------------------
module asbb_ctrl
  import asbb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t sts,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_SUM, ST_DIVS, ST_DIV, ST_LOAD, ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   flush_r, flush_nxt;

  always_comb begin
    state_nxt = state_r;
    flush_nxt = flush_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          flush_nxt = sts.end_row;
          state_nxt = (sts.end_row || sts.emit_one) ? ST_START : ST_FINISH;
        end
      end
      ST_START:  state_nxt = ST_SUM;
      ST_SUM:    if (sts.sum_done) state_nxt = ST_DIVS;
      ST_DIVS:   state_nxt = ST_DIV;
      ST_DIV:    if (sts.div_done) state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (sts.out_free) begin
          state_nxt = (flush_r && !sts.last_x) ? ST_START : ST_FINISH;
        end
      end
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      flush_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flush_r <= flush_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.accept    = (state_r == ST_IDLE) && in_valid;
    cmd.sum_start = (state_r == ST_START);
    cmd.div_start = (state_r == ST_DIVS);
    cmd.load      = (state_r == ST_LOAD) && sts.out_free;
    cmd.finish    = (state_r == ST_FINISH);
    cmd.flush     = flush_r;
  end

endmodule
`default_nettype wire

[rtl/asbb_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asbb_datapath: window store, summing, division and result register
// Holds configuration, counters, the pixel window memory and four dividers.
// ----------------------------------------------------------------------------
module asbb_datapath
  import asbb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctrl_cmd_t             cmd,
  output dp_status_t                 sts,
  input  wire logic [PIX_W-1:0]      pixel_in,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PIX_W-1:0]           pixel_out,
  output logic [COL_W-1:0]           out_column,
  output logic [COL_W-1:0]           out_row,
  output logic                       row_done,
  output logic                       image_done
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WIN_DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(WIN_DEPTH);
  localparam logic [RAD_W-1:0] RAD_MAX = RAD_W'(MAX_RADIUS);
  localparam logic [DIM_W-1:0] W_MAX = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] H_MAX = DIM_W'(MAX_HEIGHT);
  localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(SUM_W);

  // configuration
  logic [RAD_W-1:0] radius_r;
  logic [DIM_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_W'(1);
      width_r  <= W_MAX;
      height_r <= H_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_RADIUS:   radius_r <= cfg_data[RAD_W-1:0];
        REG_LINE_WIDTH:   width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [RAD_W-1:0] r_eff;
  logic [DIM_W-1:0] w_eff, h_eff;
  logic [DIV_W-1:0] divisor;

  assign r_eff   = (radius_r > RAD_MAX) ? RAD_MAX : radius_r;
  assign w_eff   = (width_r == '0) ? DIM_W'(1) : ((width_r > W_MAX) ? W_MAX : width_r);
  assign h_eff   = (height_r == '0) ? DIM_W'(1) : ((height_r > H_MAX) ? H_MAX : height_r);
  assign divisor = {r_eff, 1'b1};

  // row position
  logic [COL_W-1:0] in_col_r, next_out_r, row_r;
  logic [PTR_W-1:0] in_ptr_r, out_ptr_r;
  logic [PIX_W-1:0] first_pixel_r;
  logic             last_row;

  assign last_row     = {1'b0, row_r} >= (h_eff - DIM_W'(1));
  assign sts.end_row  = {1'b0, in_col_r} >= (w_eff - DIM_W'(1));
  assign sts.emit_one = ({1'b0, next_out_r} + {{(DIM_W-RAD_W){1'b0}}, r_eff})
                        <= {1'b0, in_col_r};
  assign sts.last_x   = (next_out_r == in_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r      <= '0;
      next_out_r    <= '0;
      row_r         <= '0;
      in_ptr_r      <= '0;
      out_ptr_r     <= '0;
      first_pixel_r <= '0;
    end else begin
      if (cmd.accept && in_col_r == '0) first_pixel_r <= pixel_in;
      if (cmd.load) begin
        next_out_r <= next_out_r + COL_W'(1);
        out_ptr_r  <= (out_ptr_r == PTR_LAST) ? '0 : out_ptr_r + PTR_W'(1);
      end
      if (cmd.finish) begin
        if (cmd.flush) begin
          in_col_r   <= '0;
          in_ptr_r   <= '0;
          next_out_r <= '0;
          out_ptr_r  <= '0;
          row_r      <= last_row ? '0 : row_r + COL_W'(1);
        end else begin
          in_col_r <= in_col_r + COL_W'(1);
          in_ptr_r <= (in_ptr_r == PTR_LAST) ? '0 : in_ptr_r + PTR_W'(1);
        end
      end
    end
  end

  // window memory
  logic [PIX_W-1:0] win_mem [WIN_DEPTH];
  logic [PTR_W-1:0] rd_addr;
  logic [PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) win_mem[in_ptr_r] <= pixel_in;
    rd_data_r <= win_mem[rd_addr];
  end

  // window sum, one term a cycle
  logic signed [JW-1:0] j_r;
  logic [DIV_W-1:0]     cnt_r;
  logic [PTR_W-1:0]     addr_r;
  logic                 term_vld_r, use_first_r;
  logic [SUM_W-1:0]     acc_r [4];
  logic                 j_neg, past_end;
  logic signed [JW-1:0] j_start;
  logic [PTR_W-1:0]     ptr_back;
  logic [PIX_W-1:0]     term;

  assign j_neg    = j_r[JW-1];
  assign past_end = !j_neg && (j_r[DIM_W-1:0] > {1'b0, in_col_r});
  assign rd_addr  = past_end ? in_ptr_r : addr_r;
  assign j_start  = $signed({2'b00, next_out_r}) - $signed({{(JW-RAD_W){1'b0}}, r_eff});
  assign ptr_back = (out_ptr_r >= {1'b0, r_eff}) ? out_ptr_r - {1'b0, r_eff}
                    : out_ptr_r + PTR_DEPTH - {1'b0, r_eff};
  assign term     = use_first_r ? first_pixel_r : rd_data_r;
  assign sts.sum_done = (cnt_r == '0) && !term_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      term_vld_r <= 1'b0;
    end else begin
      term_vld_r <= (cnt_r != '0);
      if (cmd.sum_start) cnt_r <= divisor;
      else if (cnt_r != '0) cnt_r <= cnt_r - DIV_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    use_first_r <= j_neg;
    if (cmd.sum_start) begin
      j_r    <= j_start;
      addr_r <= j_start[JW-1] ? '0 : ptr_back;
      for (int i = 0; i < 4; i++) acc_r[i] <= '0;
    end else begin
      if (cnt_r != '0) begin
        j_r <= j_r + JW'(1);
        if (!j_neg) addr_r <= (addr_r == PTR_LAST) ? '0 : addr_r + PTR_W'(1);
      end
      if (term_vld_r) begin
        for (int i = 0; i < 4; i++)
          acc_r[i] <= acc_r[i] + SUM_W'(term[8*(3-i) +: 8]);
      end
    end
  end

  // four restoring dividers, one quotient bit a cycle
  logic [SUM_W-1:0]  quo_r [4];
  logic [DIV_W-1:0]  rem_r [4];
  logic [DCNT_W-1:0] dcnt_r;

  assign sts.div_done = (dcnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dcnt_r <= DIV_STEPS;
    end else if (dcnt_r != '0) begin
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    logic [DIV_W:0] trial;
    for (int i = 0; i < 4; i++) begin
      trial = {rem_r[i], quo_r[i][SUM_W-1]};
      if (cmd.div_start) begin
        quo_r[i] <= acc_r[i];
        rem_r[i] <= '0;
      end else if (dcnt_r != '0) begin
        if (trial >= {1'b0, divisor}) begin
          rem_r[i] <= DIV_W'(trial - {1'b0, divisor});
          quo_r[i] <= {quo_r[i][SUM_W-2:0], 1'b1};
        end else begin
          rem_r[i] <= trial[DIV_W-1:0];
          quo_r[i] <= {quo_r[i][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  // result register
  logic out_vld_r;
  assign sts.out_free = !out_vld_r || out_ready;
  assign out_valid    = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pixel_out  <= {quo_r[0][7:0], quo_r[1][7:0], quo_r[2][7:0], quo_r[3][7:0]};
      out_column <= next_out_r;
      out_row    <= row_r;
      row_done   <= cmd.flush && sts.last_x;
      image_done <= cmd.flush && sts.last_x && last_row;
    end
  end

endmodule
`default_nettype wire

[rtl/argb_sliding_box_blur_row_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// timing: a request that gives a result passes through window summing, bit-serial division
//   and the result load; one result at a time
// throughput: an input that gives no result skips summing and division; results are paced
//   by the one-term-a-cycle window sum, the bit-serial dividers and result back-pressure
// reset: synchronous active-low; radius 1, width and height 4096, counters cleared
// ----------------------------------------------------------------------------
// argb_sliding_box_blur_row_unit: horizontal ARGB box blur
// Averages each pixel over columns x-r..x+r of its row, edges clamped.
// ----------------------------------------------------------------------------
module argb_sliding_box_blur_row_unit
  import asbb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  asbb_pix_if.sink     in_chan,
  asbb_res_if.source   out_chan,
  asbb_cfg_if.sink     cfg_chan
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign cfg_chan.ready = 1'b1;

  asbb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  asbb_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .pixel_in   (in_chan.pixel_in),
    .cfg_we     (cfg_chan.valid),
    .cfg_index  (cfg_chan.index),
    .cfg_data   (cfg_chan.data),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .pixel_out  (out_chan.pixel_out),
    .out_column (out_chan.out_column),
    .out_row    (out_chan.out_row),
    .row_done   (out_chan.row_done),
    .image_done (out_chan.image_done)
  );

endmodule
`default_nettype wire

[rtl/asbb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asbb_checker: port-level checks
// Result handshake, end flags, reset and config ready at the top level ports.
// ----------------------------------------------------------------------------
module asbb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] pixel_out,
  input wire logic        row_done,
  input wire logic        image_done,
  input wire logic        cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pixel_out))
    else $error("result dropped or changed while stalled");

  a_image_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && image_done |-> row_done)
    else $error("image end without row end");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_cfg_open: assert property (@(posedge clk)
    $past(rst_n) && rst_n |-> cfg_ready)
    else $error("configuration port not ready");

endmodule

bind argb_sliding_box_blur_row_unit asbb_checker u_asbb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .pixel_out  (out_chan.pixel_out),
  .row_done   (out_chan.row_done),
  .image_done (out_chan.image_done),
  .cfg_ready  (cfg_chan.ready)
);
`default_nettype wire
